// File: hdl/isotp_rr_pkg.sv
// shared types, constants and codes of the iso-tp receive reassembly block
package isotp_rr_pkg;

   // default table index width, 11 or 12 id bits
   localparam int ID_BITS_DEFAULT = 12;

   // payload bytes carried by a first frame and by a consecutive frame
   localparam int FIRST_SEG_BYTES  = 6;
   localparam int CONSEC_SEG_BYTES = 7;

   // bytes in a classic can frame
   localparam int FRAME_BYTES = 8;

   // protocol control nibble codes
   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;
   localparam logic [3:0] PCI_FLOW   = 4'h3;

   // result status codes
   typedef enum logic [3:0] {
      ST_SINGLE   = 4'd0,
      ST_FIRST    = 4'd1,
      ST_SEGMENT  = 4'd2,
      ST_COMPLETE = 4'd3,
      ST_FLOW     = 4'd4,
      ST_RESET    = 4'd5,
      ST_NOSTREAM = 4'd6,
      ST_BADSEQ   = 4'd7,
      ST_INVALID  = 4'd8
   } status_type;

   // one incoming can frame
   typedef struct packed {
      logic [11:0]     can_id;
      logic [3:0]      byte_count;
      logic [7:0][7:0] data;
   } req_item_type;

   // one result beat
   typedef struct packed {
      status_type      status;
      logic [11:0]     frame_id;
      logic [2:0]      seg_count;
      logic [6:0][7:0] seg;
      logic [11:0]     total_length;
   } rsp_item_type;

   // per-id stream table entry
   typedef struct packed {
      logic        active;
      logic [11:0] exp_len;
      logic [11:0] got;
      logic [3:0]  seq;
   } entry_type;

   // table write request
   typedef struct packed {
      logic      en;
      entry_type data;
   } tbl_wr_type;

endpackage

// File: hdl/isotp_rr_if.sv
// valid/ready channel interfaces for frames in and results out
interface isotp_rr_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] can_id;
   logic [3:0]  byte_count;
   logic [7:0]  byte0;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [7:0]  byte3;
   logic [7:0]  byte4;
   logic [7:0]  byte5;
   logic [7:0]  byte6;
   logic [7:0]  byte7;

   modport source (
      output valid, can_id, byte_count, byte0, byte1, byte2, byte3,
             byte4, byte5, byte6, byte7,
      input  ready
   );
   modport sink (
      input  valid, can_id, byte_count, byte0, byte1, byte2, byte3,
             byte4, byte5, byte6, byte7,
      output ready
   );
endinterface

interface isotp_rr_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [11:0] frame_id;
   logic [2:0]  seg_count;
   logic [7:0]  seg0;
   logic [7:0]  seg1;
   logic [7:0]  seg2;
   logic [7:0]  seg3;
   logic [7:0]  seg4;
   logic [7:0]  seg5;
   logic [7:0]  seg6;
   logic [11:0] total_length;

   modport source (
      output valid, status, frame_id, seg_count, seg0, seg1, seg2, seg3,
             seg4, seg5, seg6, total_length,
      input  ready
   );
   modport sink (
      input  valid, status, frame_id, seg_count, seg0, seg1, seg2, seg3,
             seg4, seg5, seg6, total_length,
      output ready
   );
endinterface

// File: hdl/isotp_rr_table.sv
// per-id stream table: one-port-read, one-port-write memory with a clear sweep
module isotp_rr_table #(
   parameter int ID_BITS = isotp_rr_pkg::ID_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [ID_BITS-1:0]       rd_addr,
   output isotp_rr_pkg::entry_type  rd_data,
   input  logic [ID_BITS-1:0]       wr_addr,
   input  isotp_rr_pkg::tbl_wr_type wr,
   output logic                     clearing
);
   import isotp_rr_pkg::*;

   localparam int Depth = 1 << ID_BITS;

   entry_type          mem [Depth];
   entry_type          rd_data_ff;
   logic               clearing_ff;
   logic               clearing_in;
   logic [ID_BITS-1:0] clr_addr_ff;
   logic [ID_BITS-1:0] clr_addr_in;

   // clear sweep walks every entry once after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ID_BITS{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port, shared by the sweep and the update path
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

// File: hdl/isotp_rr_decide.sv
// frame classification, stream update and result formation
module isotp_rr_decide #(
   parameter int ID_BITS = isotp_rr_pkg::ID_BITS_DEFAULT
) (
   input  isotp_rr_pkg::req_item_type item,
   input  isotp_rr_pkg::entry_type    entry,
   output isotp_rr_pkg::rsp_item_type result,
   output isotp_rr_pkg::tbl_wr_type   wr
);
   import isotp_rr_pkg::*;

   localparam logic [11:0] IdMask = 12'((1 << ID_BITS) - 1);

   logic [3:0]  n;
   logic [3:0]  n_less1;
   logic [3:0]  kind;
   logic [3:0]  low;
   logic [11:0] ff_len;
   logic [11:0] rem;
   logic [11:0] got_next;
   logic [2:0]  cap;
   logic [2:0]  avail;
   logic [2:0]  take;
   logic        first_src;

   // classify and update
   always_comb begin
      n        = (item.byte_count > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : item.byte_count;
      n_less1  = n - 4'd1;
      kind     = item.data[0][7:4];
      low      = item.data[0][3:0];
      ff_len   = {low, item.data[1]};
      rem      = (entry.got < entry.exp_len) ? entry.exp_len - entry.got : 12'd0;
      cap      = 3'd0;
      avail    = 3'd0;
      take     = 3'd0;
      got_next = entry.got;
      first_src = 1'b0;

      result.status       = ST_INVALID;
      result.frame_id     = item.can_id & IdMask;
      result.seg_count    = 3'd0;
      result.total_length = 12'd0;
      wr.en   = 1'b0;
      wr.data = entry;

      if (n != 4'd0) begin
         unique case (kind)
            PCI_SINGLE: begin
               if (low > n_less1) begin
                  result.status = ST_INVALID;
               end else if (entry.active) begin
                  // single frame aborts an open stream
                  result.status      = ST_RESET;
                  wr.en              = 1'b1;
                  wr.data.active     = 1'b0;
               end else begin
                  result.status       = ST_SINGLE;
                  result.seg_count    = low[2:0];
                  result.total_length = {8'h00, low};
               end
            end
            PCI_FIRST: begin
               if (n >= 4'd2) begin
                  cap   = (ff_len < 12'(FIRST_SEG_BYTES)) ? ff_len[2:0]
                                                           : 3'(FIRST_SEG_BYTES);
                  avail = 3'(n - 4'd2);
                  take  = (cap < avail) ? cap : avail;
                  first_src           = 1'b1;
                  result.status       = ST_FIRST;
                  result.seg_count    = take;
                  result.total_length = ff_len;
                  wr.en               = 1'b1;
                  wr.data.active      = 1'b1;
                  wr.data.exp_len     = ff_len;
                  wr.data.got         = {9'd0, take};
                  wr.data.seq         = 4'd1;
               end
            end
            PCI_CONSEC: begin
               if (!entry.active) begin
                  result.status = ST_NOSTREAM;
               end else if (low != entry.seq) begin
                  result.status       = ST_BADSEQ;
                  result.total_length = entry.exp_len;
               end else begin
                  cap   = (rem < 12'(CONSEC_SEG_BYTES)) ? rem[2:0] : 3'(CONSEC_SEG_BYTES);
                  avail = n_less1[2:0];
                  take  = (cap < avail) ? cap : avail;
                  got_next = entry.got + {9'd0, take};
                  result.seg_count    = take;
                  result.total_length = entry.exp_len;
                  wr.en               = 1'b1;
                  wr.data.got         = got_next;
                  wr.data.seq         = entry.seq + 4'd1;
                  if (got_next >= entry.exp_len) begin
                     result.status  = ST_COMPLETE;
                     wr.data.active = 1'b0;
                  end else begin
                     result.status  = ST_SEGMENT;
                  end
               end
            end
            PCI_FLOW: begin
               result.status = (n_less1 < 4'd3) ? ST_INVALID : ST_FLOW;
            end
            default: begin
               result.status = ST_INVALID;
            end
         endcase
      end

      // payload bytes, taken from offset two for a first frame, else offset one
      for (int k = 0; k < 7; k++) begin
         if (3'(k) >= result.seg_count) begin
            result.seg[k] = 8'h00;
         end else if (first_src) begin
            result.seg[k] = (k < FRAME_BYTES - 2) ? item.data[(k + 2) % FRAME_BYTES] : 8'h00;
         end else begin
            result.seg[k] = item.data[k + 1];
         end
      end
   end

endmodule

// File: hdl/isotp_receive_reassembly.sv
// iso-tp receive reassembly top level: frame in, one status beat out
//
// req_port takes one can frame per beat (id, byte count, eight data bytes);
// rsp_port returns exactly one status beat for each frame, with the accepted
// payload segment and the announced message length. The consumer glues the
// accepted segments together into the message.
// Per-id stream state sits in a table memory of 2**ID_BITS entries with a
// registered read. A frame is accepted and its entry read; in the lookup
// state, once the output register is free, the entry is updated and the
// result loaded into the output register. req_port.ready is low in lookup,
// so a new frame is taken only once the last is through the read-modify-write.
// After reset the table is swept clear, one entry per cycle, over all 2**ID_BITS
// entries (4096 at the default); req_port.ready stays low during the sweep.
// When rsp_port stalls, one finished result waits in the output register while
// the next frame is still accepted and looked up; that frame then holds in the
// lookup state until the output register is free.
module isotp_receive_reassembly #(
   parameter int ID_BITS = isotp_rr_pkg::ID_BITS_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   isotp_rr_req_if.sink  req_port,
   isotp_rr_rsp_if.source rsp_port
);
   import isotp_rr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_LOOKUP = 2'b10
   } state_type;

   state_type    state_ff;
   state_type    state_in;
   req_item_type item_ff;
   req_item_type req_item;
   rsp_item_type rsp_ff;
   rsp_item_type dec_result;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   entry_type    rd_entry;
   tbl_wr_type   dec_wr;
   tbl_wr_type   tbl_wr;
   logic         clearing;
   logic         accept;
   logic         out_free;
   logic         finish;

   // input beat gathering
   assign req_item.can_id     = req_port.can_id;
   assign req_item.byte_count = req_port.byte_count;
   assign req_item.data       = {req_port.byte7, req_port.byte6, req_port.byte5,
                                 req_port.byte4, req_port.byte3, req_port.byte2,
                                 req_port.byte1, req_port.byte0};

   // handshake control
   assign req_port.ready = (state_ff == S_IDLE) && !clearing;
   assign accept         = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign finish         = (state_ff == S_LOOKUP) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_LOOKUP;
         S_LOOKUP: if (finish) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // frame and result holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (finish) begin
         rsp_ff <= dec_result;
      end
   end

   // stream table
   assign tbl_wr.en   = dec_wr.en && finish;
   assign tbl_wr.data = dec_wr.data;

   isotp_rr_table #(
      .ID_BITS (ID_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_port.can_id[ID_BITS-1:0]),
      .rd_data  (rd_entry),
      .wr_addr  (item_ff.can_id[ID_BITS-1:0]),
      .wr       (tbl_wr),
      .clearing (clearing)
   );

   isotp_rr_decide #(
      .ID_BITS (ID_BITS)
   ) u_decide (
      .item   (item_ff),
      .entry  (rd_entry),
      .result (dec_result),
      .wr     (dec_wr)
   );

   // result beat
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_ff.status;
   assign rsp_port.frame_id     = rsp_ff.frame_id;
   assign rsp_port.seg_count    = rsp_ff.seg_count;
   assign rsp_port.seg0         = rsp_ff.seg[0];
   assign rsp_port.seg1         = rsp_ff.seg[1];
   assign rsp_port.seg2         = rsp_ff.seg[2];
   assign rsp_port.seg3         = rsp_ff.seg[3];
   assign rsp_port.seg4         = rsp_ff.seg[4];
   assign rsp_port.seg5         = rsp_ff.seg[5];
   assign rsp_port.seg6         = rsp_ff.seg[6];
   assign rsp_port.total_length = rsp_ff.total_length;

`ifndef SYNTHESIS
   // table is only written while a lookup finishes, never during the sweep
   assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en |-> (state_ff == S_LOOKUP) && !clearing)
      else $error("table write outside lookup");

   // an accepted frame always moves into lookup
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP))
      else $error("accepted frame not looked up");

   // a finished lookup always shows a result beat in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished lookup lost its result");

   // a first frame result goes together with opening the stream
   assert property (@(posedge clock) disable iff (reset)
      (finish && (dec_result.status == ST_FIRST)) |-> (tbl_wr.en && tbl_wr.data.active))
      else $error("first frame did not open stream");
`endif

endmodule
